// ===== sv/scfla_pkg.sv =====
// shared constants, types and helpers of the size-class allocator
`timescale 1ns / 1ps
package scfla_pkg;
  localparam int HeapGranules = 8192;
  localparam int SizeClasses  = 16;
  localparam int GranuleBytes = 8;
  localparam int MaxSmallBytes = 128;
  localparam int GW = 14;                    // granule pointer width
  localparam int CW = 4;                     // class index width
  localparam int AW = 13;                    // link ram address width
  localparam logic [GW-1:0] NIL_LINK = 14'h2000;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0, CMD_FREE = 2'd1, CMD_REALLOC = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0, ST_FREED = 2'd1, ST_TOO_LARGE = 2'd2, ST_NO_MEM = 2'd3
  } status_t;

  typedef enum logic {
    CFG_REFILL = 1'b0, CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_t;

  // class index plus a too-large flag
  typedef struct packed {
    logic          big;
    logic [CW-1:0] cls;
  } cls_t;

  function automatic cls_t class_of(input logic [15:0] bytes);
    cls_t r;
    logic [15:0] b;
    r.big = 1'b0;
    r.cls = '0;
    b = (bytes == 16'd0) ? 16'd8 : bytes;
    if (bytes > 16'(MaxSmallBytes)) r.big = 1'b1;
    else r.cls = CW'((b + 16'd7) >> 3) - CW'(1);
    return r;
  endfunction

  function automatic logic is_nil(input logic [GW-1:0] g);
    return g[GW-1];
  endfunction
endpackage

// ===== sv/scfla_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module scfla_ram #(
  parameter int Width = 14,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/size_class_free_list_allocator.sv =====
// top level of the size-class free-list allocator
//
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, cmd, sizes, address  | request in
//  out     | out_valid/out_ready, result_addr,status | result out
//  cfg     | cfg_we, cfg_index, cfg_data             | register write
//
// one request at a time; a hit on a class list goes through S_ALLOC, S_LINKRD, S_POP and S_DONE,
// a refill adds one link ram write per carved block after the first (up to refill_r blocks)
// and a pool too short for a full refill needs a restoring divider for left / size
// a borrow scans up to 16 class heads, one per cycle
// reset is synchronous; class heads reset to null, link ram is not cleared
// out stall holds the result register; a new request is taken once it empties
`timescale 1ns / 1ps
module size_class_free_list_allocator import scfla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_req_bytes,
  input  logic [15:0] in_old_bytes,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_addr,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_ALLOC, S_LINKRD, S_POP, S_CHUNK, S_DIV, S_GROW,
    S_SCAN, S_SCANRD, S_CARVE, S_DONE
  } state_t;

  state_t state_r;
  logic [GW-1:0] heads_r [SizeClasses];
  logic [GW-1:0] pool_start_r, pool_end_r, heap_top_r, heap_total_r;
  logic [5:0]  refill_r;
  logic [13:0] limit_r;
  logic [1:0]  cmd_r;
  logic [15:0] req_r, old_r, addr_r;
  logic [CW-1:0] cls_r, scan_r;
  logic [5:0]  n_r, k_r;
  logic [GW-1:0] at_r, cur_r, need_r;
  logic [GW-1:0] quo_r, rem_r;
  logic [3:0]  div_cnt_r;
  logic        out_valid_r;
  logic [15:0] res_addr_r;
  logic [1:0]  res_st_r;

  // link ram ports
  logic          l_we;
  logic [AW-1:0] l_waddr, l_raddr;
  logic [GW-1:0] l_wdata, l_rdata;

  scfla_ram #(.Width(GW), .Depth(HeapGranules)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  cls_t req_c, old_c;
  assign req_c = class_of(req_r);
  assign old_c = class_of(old_r);

  logic [GW-1:0] size_g, left, head_cur, extra, get, lim, grow_end;
  logic [GW+1:0] need_w;
  logic [GW:0]   grow_sum;
  logic [GW-1:0] free_g;
  assign size_g   = GW'(cls_r) + GW'(1);
  assign left     = (pool_end_r > pool_start_r) ? pool_end_r - pool_start_r : '0;
  assign head_cur = heads_r[cls_r];
  assign need_w   = (GW+2)'(size_g) * (GW+2)'(n_r);
  // heap_total*8>>4 bytes rounded up to granules
  assign extra    = GW'(((heap_total_r >> 1) + GW'(7)) >> 3);
  assign get      = GW'({need_r, 1'b0}) + extra;
  assign lim      = (limit_r > 14'(HeapGranules)) ? 14'(HeapGranules) : limit_r;
  assign grow_sum = {1'b0, heap_top_r} + {1'b0, get} + {1'b0, need_r[GW-1], 13'd0};
  assign grow_end = heap_top_r + get;
  assign free_g   = GW'(addr_r >> 3);

  assign in_ready        = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_result_addr = res_addr_r;
  assign out_status      = res_st_r;

  // link ram drive
  always_comb begin
    l_we = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    l_raddr = AW'(head_cur);
    case (state_r)
      S_FREE: begin
        l_we = !old_c.big && !free_g[GW-1];
        l_waddr = AW'(free_g);
        l_wdata = heads_r[old_c.cls];
      end
      S_CHUNK: begin
        // leftover piece goes on its own class list before growth
        l_we = (left != '0) && (left < size_g) && !pool_start_r[GW-1];
        l_waddr = AW'(pool_start_r);
        l_wdata = heads_r[CW'(left - GW'(1))];
      end
      S_SCAN: l_raddr = AW'(heads_r[scan_r]);
      S_CARVE: begin
        // a single block links nothing
        l_we = !cur_r[GW-1] && (n_r > 6'd1);
        l_waddr = AW'(cur_r);
        l_wdata = (k_r == n_r - 6'd1) ? NIL_LINK : cur_r + size_g;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < SizeClasses; i++) heads_r[i] <= NIL_LINK;
      pool_start_r <= '0;
      pool_end_r   <= '0;
      heap_top_r   <= '0;
      heap_total_r <= '0;
      refill_r     <= 6'd20;
      limit_r      <= 14'd8192;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_REFILL:     refill_r <= cfg_data[5:0];
          CFG_HEAP_LIMIT: limit_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r  <= in_cmd;
          req_r  <= in_req_bytes;
          old_r  <= in_old_bytes;
          addr_r <= in_block_addr;
          res_addr_r <= '0;
          res_st_r   <= ST_NO_MEM;
          state_r <= (cmd_t'(in_cmd) == CMD_ALLOC) ? S_ALLOC :
                     (cmd_t'(in_cmd) == CMD_NONE) ? S_DONE : S_FREE;
        end
        S_FREE: begin
          if (!old_c.big && !free_g[GW-1]) heads_r[old_c.cls] <= free_g;
          if (cmd_t'(cmd_r) == CMD_FREE) begin
            res_st_r <= old_c.big ? ST_TOO_LARGE : ST_FREED;
            state_r <= S_DONE;
          end else state_r <= S_ALLOC;
        end
        S_ALLOC: begin
          cls_r <= req_c.cls;
          if (req_c.big) begin
            res_st_r <= ST_TOO_LARGE;
            state_r <= S_DONE;
          end else if (!is_nil(heads_r[req_c.cls])) begin
            state_r <= S_LINKRD;
          end else begin
            n_r <= (refill_r == 6'd0) ? 6'd1 : refill_r;
            state_r <= S_CHUNK;
          end
        end
        S_LINKRD: state_r <= S_POP; // ram read of the head's link
        S_POP: begin
          heads_r[cls_r] <= l_rdata;
          res_addr_r <= {head_cur[12:0], 3'b000};
          res_st_r <= ST_ALLOCATED;
          state_r <= S_DONE;
        end
        S_CHUNK: begin
          need_r <= GW'(need_w);
          if ({2'b0, left} > need_w) begin
            at_r <= pool_start_r;
            pool_start_r <= pool_start_r + GW'(need_w);
            k_r <= 6'd1;
            cur_r <= pool_start_r + size_g;
            if (n_r > 6'd1) heads_r[cls_r] <= pool_start_r + size_g;
            state_r <= S_CARVE;
          end else if (left >= size_g) begin
            quo_r <= '0;
            rem_r <= left;
            div_cnt_r <= '0;
            state_r <= S_DIV;
          end else begin
            if (left != '0) heads_r[CW'(left - GW'(1))] <= pool_start_r;
            state_r <= S_GROW;
          end
        end
        S_DIV: begin
          // restoring divide left / size_g, one quotient bit per cycle
          if ({4'd0, rem_r} >= ({4'd0, size_g} << (4'd13 - div_cnt_r))) begin
            rem_r <= rem_r - GW'({4'd0, size_g} << (4'd13 - div_cnt_r));
            quo_r[4'd13 - div_cnt_r] <= 1'b1;
          end
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd13) begin
            // carve on the following cycle using quotient
            state_r <= S_CARVE;
            n_r <= 6'(quo_r | ((({4'd0, rem_r} >= {4'd0, size_g}) ? GW'(1) : GW'(0))));
            at_r <= pool_start_r;
            pool_start_r <= pool_start_r + (left - (rem_r -
              (({4'd0, rem_r} >= {4'd0, size_g}) ? size_g : GW'(0))));
            k_r <= 6'd1;
            cur_r <= pool_start_r + size_g;
            if ((quo_r | ((({4'd0, rem_r} >= {4'd0, size_g}) ? GW'(1) : GW'(0))))
                > GW'(1))
              heads_r[cls_r] <= pool_start_r + size_g;
          end
        end
        S_GROW: begin
          if (!grow_sum[GW] && ({1'b0, heap_top_r} + {1'b0, get} <= {1'b0, lim})) begin
            pool_start_r <= heap_top_r;
            pool_end_r <= grow_end;
            heap_top_r <= grow_end;
            heap_total_r <= heap_total_r + get;
            state_r <= S_CHUNK;
          end else begin
            scan_r <= cls_r;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!is_nil(heads_r[scan_r])) state_r <= S_SCANRD;
          else if (scan_r == CW'(SizeClasses - 1)) begin
            pool_start_r <= '0;
            pool_end_r <= '0;
            res_st_r <= ST_NO_MEM;
            state_r <= S_DONE;
          end else scan_r <= scan_r + CW'(1);
        end
        S_SCANRD: begin
          heads_r[scan_r] <= l_rdata;
          pool_start_r <= heads_r[scan_r];
          pool_end_r <= heads_r[scan_r] + GW'(scan_r) + GW'(1);
          state_r <= S_CHUNK;
        end
        S_CARVE: begin
          if (k_r >= n_r - 6'd1 || n_r <= 6'd1) begin
            res_addr_r <= {at_r[12:0], 3'b000};
            res_st_r <= ST_ALLOCATED;
            state_r <= S_DONE;
          end
          k_r <= k_r + 6'd1;
          cur_r <= cur_r + size_g;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
